>>> design/prr_pkg.sv
// Shared types, codes and constants of the polyphase rational resampler.
package prr_pkg;

  // Default geometry; the top level hands these down as parameters.
  localparam int unsigned MAX_PHASES_DEF = 32;
  localparam int unsigned TAPS_DEF       = 64;

  // Largest phase step (decimation factor).
  localparam int unsigned DECIM_LIMIT = 32;

  // Sample/coef arithmetic: Q1.15 x Q2.14 -> round at bit 14.
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned ROUND_BIAS = 8192;
  localparam int unsigned PROD_W     = 32;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef logic        [1:0]  op_t;
  typedef logic signed [15:0] sample_t;
  typedef logic signed [15:0] coef_t;
  typedef logic        [10:0] coef_idx_t;
  typedef logic        [1:0]  cfg_idx_t;
  typedef logic        [6:0]  cfg_data_t;

  // Input op codes.
  localparam op_t OP_PUSH  = 2'd0;
  localparam op_t OP_COEF  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_INTERP = 2'd0;
  localparam cfg_idx_t CFG_DECIM  = 2'd1;
  localparam cfg_idx_t CFG_TAPS   = 2'd2;

  // Register reset values.
  localparam logic [5:0] INTERP_RST = 6'd1;
  localparam logic [5:0] DECIM_RST  = 6'd1;
  localparam logic [6:0] TAPS_RST   = 7'd64;

  // Work kinds handed from front to back.
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_COEF  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e     kind;
    sample_t   sample;
    coef_idx_t coef_idx;
    coef_t     coef_val;
  } item_t;

  // Raw register values as written.
  typedef struct packed {
    logic [5:0] interp;
    logic [5:0] decim;
    logic [6:0] taps;
  } cfg_t;

  typedef struct packed {
    sample_t sample;
    logic    last;
  } result_t;

endpackage

>>> design/prr_if.sv
// Channel interfaces: input items, result items and register writes.
interface prr_in_if;
  import prr_pkg::*;
  logic      valid;
  logic      ready;
  op_t       op;
  sample_t   sample_in;
  coef_idx_t coef_index;
  coef_t     coef_value;
  modport source (output valid, op, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, op, sample_in, coef_index, coef_value, output ready);
endinterface

interface prr_out_if;
  import prr_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    last_of_run;
  modport source (output valid, sample_out, last_of_run, input ready);
  modport sink   (input valid, sample_out, last_of_run, output ready);
endinterface

interface prr_cfg_if;
  import prr_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/prr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/prr_fifo.sv
// Short work queue between the front and back parts.
module prr_fifo #(
  parameter int unsigned DEPTH = prr_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  prr_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output prr_pkg::item_t item_o
);
  import prr_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          slot_q [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

>>> design/prr_front.sv
// Front part: accepts input beats, drops no-op items, queues the rest.
module prr_front #(
  parameter int unsigned MAX_PHASES = prr_pkg::MAX_PHASES_DEF,
  parameter int unsigned TAPS       = prr_pkg::TAPS_DEF
) (
  prr_in_if.sink         in_i,
  input  logic           full_i,
  output logic           push_o,
  output prr_pkg::item_t item_o
);
  import prr_pkg::*;

  localparam int unsigned STORE_SIZE = MAX_PHASES * TAPS;

  logic keep;

  assign in_i.ready = !full_i;

  // op 3 and coefficient writes beyond the store are taken and dropped
  always_comb begin
    keep          = 1'b0;
    item_o.kind   = KIND_PUSH;
    unique case (in_i.op)
      OP_PUSH: begin
        keep        = 1'b1;
        item_o.kind = KIND_PUSH;
      end
      OP_COEF: begin
        keep        = (32'(in_i.coef_index) < STORE_SIZE);
        item_o.kind = KIND_COEF;
      end
      OP_CLEAR: begin
        keep        = 1'b1;
        item_o.kind = KIND_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    item_o.sample   = in_i.sample_in;
    item_o.coef_idx = in_i.coef_index;
    item_o.coef_val = in_i.coef_value;
  end

  assign push_o = in_i.valid && !full_i && keep;

endmodule

>>> design/prr_back.sv
// Back part: history ring, coefficient store, MAC sequencer, output register.
module prr_back #(
  parameter int unsigned MAX_PHASES = prr_pkg::MAX_PHASES_DEF,
  parameter int unsigned TAPS       = prr_pkg::TAPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  prr_pkg::cfg_t    cfg_i,
  input  logic             item_valid_i,
  input  prr_pkg::item_t   item_i,
  output logic             item_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output prr_pkg::result_t out_o
);
  import prr_pkg::*;

  localparam int unsigned STORE_SIZE = MAX_PHASES * TAPS;
  localparam int unsigned HA_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned CA_W  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(TAPS + 1);
  localparam int unsigned ACC_W = PROD_W + $clog2(TAPS + 1) + 1;
  localparam int unsigned RW    = ACC_W + 1 - FRAC_SHIFT;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_ROUND = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // effective register values
  logic [5:0]       l_eff, m_eff;
  logic [CNT_W-1:0] p_eff;

  always_comb begin
    if (cfg_i.interp == '0) begin
      l_eff = 6'd1;
    end else if (32'(cfg_i.interp) > MAX_PHASES) begin
      l_eff = 6'(MAX_PHASES);
    end else begin
      l_eff = cfg_i.interp;
    end
    if (cfg_i.decim == '0) begin
      m_eff = 6'd1;
    end else if (32'(cfg_i.decim) > DECIM_LIMIT) begin
      m_eff = 6'(DECIM_LIMIT);
    end else begin
      m_eff = cfg_i.decim;
    end
    if (cfg_i.taps == '0) begin
      p_eff = CNT_W'(1);
    end else if (32'(cfg_i.taps) > TAPS) begin
      p_eff = CNT_W'(TAPS);
    end else begin
      p_eff = CNT_W'(cfg_i.taps);
    end
  end

  // control state
  logic [HA_W-1:0]  newest_q, newest_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [5:0]       phase_q, phase_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CA_W-1:0]  caddr_q, caddr_d;
  logic [HA_W-1:0]  haddr_q, haddr_d;
  logic             rd_v_q, rd_v_d, tap_ok_q, tap_ok_d;
  logic             prod_v_q, prod_v_d;
  logic             out_valid_q, out_valid_d;

  // datapath
  logic signed [PROD_W-1:0] mult;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  sample_t                  out_sample_q, out_sample_d;
  logic                     out_last_q, out_last_d;

  // memories
  logic            hist_we, coef_we;
  logic [15:0]     hist_rd, coef_rd;
  logic [CA_W-1:0] coef_waddr;

  // round and saturate
  logic signed [ACC_W:0]  biased;
  logic signed [RW-1:0]   scaled;
  logic                   fits;
  sample_t                rounded;
  logic [6:0]             phase_next;

  assign biased  = {acc_q[ACC_W-1], acc_q} + (ACC_W + 1)'(ROUND_BIAS);
  assign scaled  = biased[ACC_W:FRAC_SHIFT];
  assign fits    = (&scaled[RW-1:15]) || !(|scaled[RW-1:15]);
  assign rounded = fits ? scaled[15:0] : (scaled[RW-1] ? 16'sh8000 : 16'sh7fff);

  assign phase_next = {1'b0, phase_q} + {1'b0, m_eff};
  assign coef_waddr = CA_W'(item_i.coef_idx);

  // signed 16 x 16 product, kept apart so the zero arm cannot make it unsigned
  assign mult = $signed(coef_rd) * $signed(hist_rd);

  always_comb begin
    state_d      = state_q;
    newest_d     = newest_q;
    fill_d       = fill_q;
    phase_d      = phase_q;
    k_d          = k_q;
    caddr_d      = caddr_q;
    haddr_d      = haddr_q;
    rd_v_d       = 1'b0;
    tap_ok_d     = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    item_pop_o   = 1'b0;
    hist_we      = 1'b0;
    coef_we      = 1'b0;
    acc_d        = prod_v_q ? acc_q + ACC_W'(prod_q) : acc_q;

    // product stage: taps older than the history fill read as zero
    prod_v_d = rd_v_q;
    prod_d   = tap_ok_q ? mult : '0;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          unique case (item_i.kind)
            KIND_PUSH: begin
              newest_d = (newest_q == HA_W'(TAPS - 1)) ? '0 : newest_q + 1'b1;
              hist_we  = 1'b1;
              if (fill_q != CNT_W'(TAPS)) begin
                fill_d = fill_q + 1'b1;
              end
              state_d = ST_CHECK;
            end
            KIND_COEF: begin
              coef_we = 1'b1;
            end
            KIND_CLEAR: begin
              fill_d  = '0;
              phase_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (phase_q < l_eff) begin
          acc_d   = '0;
          k_d     = '0;
          caddr_d = CA_W'(32'(phase_q) * TAPS + 32'(p_eff) - 1);
          haddr_d = newest_q;
          state_d = ST_MAC;
        end else begin
          phase_d = phase_q - l_eff;
          state_d = ST_IDLE;
        end
      end
      ST_MAC: begin
        rd_v_d   = 1'b1;
        tap_ok_d = (k_q < fill_q);
        k_d      = k_q + 1'b1;
        caddr_d  = caddr_q - 1'b1;
        haddr_d  = (haddr_q == '0) ? HA_W'(TAPS - 1) : haddr_q - 1'b1;
        if (k_q + 1'b1 == p_eff) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !prod_v_q) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_sample_d = rounded;
          out_last_d   = (phase_next >= {1'b0, l_eff});
          phase_d      = phase_next[5:0];
          state_d      = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      newest_q    <= '0;
      fill_q      <= '0;
      phase_q     <= '0;
      k_q         <= '0;
      caddr_q     <= '0;
      haddr_q     <= '0;
      rd_v_q      <= 1'b0;
      tap_ok_q    <= 1'b0;
      prod_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      newest_q    <= newest_d;
      fill_q      <= fill_d;
      phase_q     <= phase_d;
      k_q         <= k_d;
      caddr_q     <= caddr_d;
      haddr_q     <= haddr_d;
      rd_v_q      <= rd_v_d;
      tap_ok_q    <= tap_ok_d;
      prod_v_q    <= prod_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
  end

  prr_ram #(.WIDTH(16), .DEPTH(TAPS)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (newest_d),
    .wdata_i (item_i.sample),
    .raddr_i (haddr_q),
    .rdata_o (hist_rd)
  );

  prr_ram #(.WIDTH(16), .DEPTH(STORE_SIZE)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (item_i.coef_val),
    .raddr_i (caddr_q),
    .rdata_o (coef_rd)
  );

  assign out_valid_o = out_valid_q;
  assign out_o.sample = out_sample_q;
  assign out_o.last   = out_last_q;

endmodule

>>> design/polyphase_rational_resampler.sv
// Top level of the polyphase rational resampler (L/M, real, Q1.15 in and out).
//
//  channel | dir | beat carries                              | accepted when
//  --------+-----+-------------------------------------------+------------------
//  in_i    | in  | op, sample_in, coef_index, coef_value     | valid && ready
//  out_o   | out | sample_out, last_of_run                   | valid && ready
//  cfg_i   | in  | index (0 interp, 1 decim, 2 taps), data   | valid && ready
//
// Work: coefficient writes and clears are handled by the back part in its idle
// state; dropped items never reach it. For each of its outputs a push runs the
// single MAC loop over the P taps in use, one tap per cycle with one read port
// on each RAM.
// Reset: asynchronous, active low. The history counts as empty through a fill
// count, so no clearing pass runs; the coefficient store is not cleared.
// Stalls: a two-entry queue lets the input side keep taking beats while the
// back part works, and the output register holds a result while the back
// part starts on the next one. The config port is always ready.
module polyphase_rational_resampler #(
  parameter int unsigned MAX_PHASES = prr_pkg::MAX_PHASES_DEF,
  parameter int unsigned TAPS       = prr_pkg::TAPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  prr_in_if.sink     in_i,
  prr_out_if.source  out_o,
  prr_cfg_if.sink    cfg_i
);
  import prr_pkg::*;

  // Config registers, written raw; clamping happens where they are used.
  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_INTERP: cfg_d.interp = cfg_i.data[5:0];
        CFG_DECIM:  cfg_d.decim  = cfg_i.data[5:0];
        CFG_TAPS:   cfg_d.taps   = cfg_i.data;
        default: begin
          // index beyond the register list: ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interp <= INTERP_RST;
      cfg_q.decim  <= DECIM_RST;
      cfg_q.taps   <= TAPS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front -> queue -> back
  logic    q_push, q_full, q_pop, q_valid;
  item_t   q_in, q_out;
  result_t res;
  logic    res_valid;

  prr_front #(.MAX_PHASES(MAX_PHASES), .TAPS(TAPS)) u_front (
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (q_push),
    .item_o (q_in)
  );

  prr_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  prr_back #(.MAX_PHASES(MAX_PHASES), .TAPS(TAPS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_out),
    .item_pop_o   (q_pop),
    .out_valid_o  (res_valid),
    .out_ready_i  (out_o.ready),
    .out_o        (res)
  );

  assign out_o.valid       = res_valid;
  assign out_o.sample_out  = res.sample;
  assign out_o.last_of_run = res.last;

endmodule

>>> design/prr_checker.sv
// Port-level checks of the resampler, bound to the top level.
module prr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_op_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_sample_i,
  input logic        out_last_i
);
  import prr_pkg::*;

  logic       push_acc, last_acc;
  logic [7:0] pend_q;
  logic       seen_push_q;

  assign push_acc = in_valid_i && in_ready_i && (in_op_i == OP_PUSH);
  assign last_acc = out_valid_i && out_ready_i && out_last_i;

  // pushes not yet closed by a last beat; sticks once saturated
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      seen_push_q <= 1'b0;
    end else begin
      if (push_acc) begin
        seen_push_q <= 1'b1;
      end
      if (pend_q != 8'hff) begin
        pend_q <= pend_q + 8'(push_acc) - 8'(last_acc);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i)
      && $stable(out_last_i))
    else $error("result dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result valid right after reset");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_push_q)
    else $error("result before any sample was pushed");

  a_last_has_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_acc |-> pend_q != '0)
    else $error("more end-of-run beats than pushed samples");

endmodule

bind polyphase_rational_resampler prr_checker u_prr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out),
  .out_last_i   (out_o.last_of_run)
);
